>>> design/dam_pkg.sv
// ----------------------------------------------------------------------------
// dam_pkg: shared constants for the DRAM address mapper
// Table sizes, operation codes, register indexes and count limits.
// ----------------------------------------------------------------------------
`default_nettype none

package dam_pkg;

  // Table sizes and supported address width
  localparam int MAP_SLOTS     = 64;   // 8 .. 64
  localparam int XOR_ENTRIES   = 16;   // 1 .. 64
  localparam int ADDRESS_WIDTH = 64;   // 8 .. 64

  // XOR chain: entries folded per pipeline stage
  localparam int XOR_PER_STAGE = 4;
  localparam int XOR_STAGES    = (XOR_ENTRIES + XOR_PER_STAGE - 1) / XOR_PER_STAGE;

  // Operation codes (in_tuser)
  localparam logic [1:0] OP_DECODE = 2'd0;
  localparam logic [1:0] OP_SLOT   = 2'd1;
  localparam logic [1:0] OP_XOR    = 2'd2;

  // Configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_BITS   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANK_BITS      = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BANKGROUP_BITS = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BANK_BITS      = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_BITS       = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_BITS    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BYTE_BITS      = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ADDR_BITS      = 4'd7;

  // Count limits per field
  localparam logic [2:0] CHANNEL_MAX   = 3'd4;
  localparam logic [2:0] RANK_MAX      = 3'd4;
  localparam logic [2:0] BANKGROUP_MAX = 3'd4;
  localparam logic [2:0] BANK_MAX      = 3'd6;
  localparam logic [4:0] ROW_MAX       = 5'd20;
  localparam logic [4:0] COLUMN_MAX    = 5'd16;
  localparam logic [3:0] BYTE_MAX      = 4'd8;
  localparam logic [6:0] ADDR_BITS_MAX = 7'd64;
  localparam logic [6:0] ADDR_BITS_RST = 7'd64;

  // Low n bits set, n = 0 .. 20
  function automatic logic [19:0] low_mask(input logic [4:0] n);
    logic [19:0] one;
    one = 20'd1;
    return (one << n) - 20'd1;
  endfunction

endpackage

`default_nettype wire

>>> design/dram_address_mapper.sv
// ----------------------------------------------------------------------------
// dram_address_mapper
// Pipelined flat-address to DRAM coordinate translator with XOR bank hashing.
// ----------------------------------------------------------------------------
// One word enters per cycle when the output side keeps up. A decode word
// passes through these registers in order after it is accepted:
// one input stage, one stage per group of four XOR entries, a gather stage
// that picks one address bit per slot, a field extract stage and the output
// register that flattens bank group and bank. Slot and XOR table writes go
// down the same pipe and take effect at the stage that reads that table, so
// they are ordered exactly against the decodes around them; they produce no
// output word. Back-pressure stalls only the stages that are full.
`default_nettype none

module dram_address_mapper (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input: operation, address, entry/slot writes
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [87:0] in_tdata,   // address[63:0], entry_index[69:64],
                                       // first_bit[75:70], second_bit[81:76],
                                       // entry_enable[82], zero[87:83]
  input  wire logic [1:0]  in_tuser,   // operation[1:0]
  // result
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [79:0]      out_tdata,  // channel[3:0], rank[7:4], bankgroup[15:8],
                                       // bank[29:16], row[49:30], column[65:50],
                                       // byte_offset[73:66], out_of_range[74],
                                       // zero[79:75]
  // configuration writes
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [dam_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dam_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int XS  = dam_pkg::XOR_STAGES;
  localparam int XPS = dam_pkg::XOR_PER_STAGE;
  localparam int NS  = dam_pkg::MAP_SLOTS;
  localparam int NX  = dam_pkg::XOR_ENTRIES;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] addr;
    logic [5:0]  idx;
    logic [5:0]  fb;
    logic [5:0]  sb;
    logic        en;
    logic        oor;
  } item_t;

  // Configuration registers
  logic [2:0] cfg_ch_r, cfg_rk_r, cfg_bg_r, cfg_bk_r;
  logic [4:0] cfg_row_r, cfg_col_r;
  logic [3:0] cfg_byte_r;
  logic [6:0] cfg_aw_r;

  // Tables
  logic [5:0] slot_r [NS];
  logic       xor_en_r [NX];
  logic [5:0] xor_first_r [NX];
  logic [5:0] xor_second_r [NX];

  // Pipeline registers
  item_t            p_r [XS+1];
  logic [XS:0]      p_v_r;
  logic [NS-1:0]    gat_bits_r;
  logic             gat_oor_r, gat_v_r;
  logic [3:0]       asm_ch_r, asm_rk_r, asm_bgf_r;
  logic [5:0]       asm_bkf_r;
  logic [19:0]      asm_row_r;
  logic [15:0]      asm_col_r;
  logic [7:0]       asm_byte_r;
  logic             asm_oor_r, asm_v_r;
  logic [3:0]       out_ch_r, out_rk_r;
  logic [7:0]       out_bg_r;
  logic [13:0]      out_bank_r;
  logic [19:0]      out_row_r;
  logic [15:0]      out_col_r;
  logic [7:0]       out_byte_r;
  logic             out_oor_r, out_v_r;

  // Combinational
  logic [XS:0]   adv;
  logic          gat_adv, asm_adv, out_adv;
  item_t         in_item;
  item_t         x_nxt [1:XS];
  logic [NX-1:0] xor_wr;
  logic [NS-1:0] slot_wr;
  logic [NS-1:0] g_nxt;
  logic [6:0]    aw_eff;
  logic [2:0]    cnt_ch, cnt_rk, cnt_bg, cnt_bk;
  logic [4:0]    cnt_row, cnt_col;
  logic [3:0]    cnt_byte;
  logic [5:0]    off_rk, off_bg, off_bk, off_row, off_col, off_byte;
  logic [7:0]    bg_nxt;
  logic [13:0]   bank_nxt;

  // Stall chain: a stage moves when it is empty or its successor moves
  always_comb begin
    out_adv = !out_v_r || out_tready;
    asm_adv = !asm_v_r || out_adv;
    gat_adv = !gat_v_r || asm_adv;
    adv[XS] = !p_v_r[XS] || gat_adv;
    for (int s = XS - 1; s >= 0; s--) begin
      adv[s] = !p_v_r[s] || adv[s+1];
    end
  end

  assign in_tready = adv[0];
  assign cfg_ready = 1'b1;

  // Effective address width and input capture
  always_comb begin
    aw_eff = (cfg_aw_r > dam_pkg::ADDR_BITS_MAX) ? dam_pkg::ADDR_BITS_MAX : cfg_aw_r;
    if (aw_eff > 7'(dam_pkg::ADDRESS_WIDTH)) aw_eff = 7'(dam_pkg::ADDRESS_WIDTH);
    in_item.op   = in_tuser;
    in_item.addr = in_tdata[63:0];
    in_item.idx  = in_tdata[69:64];
    in_item.fb   = in_tdata[75:70];
    in_item.sb   = in_tdata[81:76];
    in_item.en   = in_tdata[82];
    in_item.oor  = 1'b0;
    for (int b = 0; b < 64; b++) begin
      if (7'(b) >= aw_eff && in_tdata[b]) in_item.oor = 1'b1;
    end
  end

  // XOR chain: each stage folds its group of entries in index order
  always_comb begin
    for (int s = 1; s <= XS; s++) x_nxt[s] = p_r[s-1];
    for (int e = 0; e < NX; e++) begin
      if (xor_en_r[e]) begin
        x_nxt[e/XPS+1].addr[xor_first_r[e]] =
          x_nxt[e/XPS+1].addr[xor_first_r[e]] ^ x_nxt[e/XPS+1].addr[xor_second_r[e]];
      end
    end
  end

  // Table write strobes, taken at the stage that reads the table
  always_comb begin
    for (int e = 0; e < NX; e++) begin
      xor_wr[e] = adv[e/XPS+1] && p_v_r[e/XPS] && p_r[e/XPS].op == dam_pkg::OP_XOR &&
                  p_r[e/XPS].idx == 6'(e);
    end
    for (int k = 0; k < NS; k++) begin
      slot_wr[k] = gat_adv && p_v_r[XS] && p_r[XS].op == dam_pkg::OP_SLOT &&
                   p_r[XS].idx == 6'(k);
    end
  end

  // Gather: one address bit per slot
  always_comb begin
    for (int k = 0; k < NS; k++) g_nxt[k] = p_r[XS].addr[slot_r[k]];
  end

  // Saturated counts and slot offsets of each field
  always_comb begin
    cnt_ch   = (cfg_ch_r   > dam_pkg::CHANNEL_MAX)   ? dam_pkg::CHANNEL_MAX   : cfg_ch_r;
    cnt_rk   = (cfg_rk_r   > dam_pkg::RANK_MAX)      ? dam_pkg::RANK_MAX      : cfg_rk_r;
    cnt_bg   = (cfg_bg_r   > dam_pkg::BANKGROUP_MAX) ? dam_pkg::BANKGROUP_MAX : cfg_bg_r;
    cnt_bk   = (cfg_bk_r   > dam_pkg::BANK_MAX)      ? dam_pkg::BANK_MAX      : cfg_bk_r;
    cnt_row  = (cfg_row_r  > dam_pkg::ROW_MAX)       ? dam_pkg::ROW_MAX       : cfg_row_r;
    cnt_col  = (cfg_col_r  > dam_pkg::COLUMN_MAX)    ? dam_pkg::COLUMN_MAX    : cfg_col_r;
    cnt_byte = (cfg_byte_r > dam_pkg::BYTE_MAX)      ? dam_pkg::BYTE_MAX      : cfg_byte_r;
    off_rk   = 6'(cnt_ch);
    off_bg   = off_rk  + 6'(cnt_rk);
    off_bk   = off_bg  + 6'(cnt_bg);
    off_row  = off_bk  + 6'(cnt_bk);
    off_col  = off_row + 6'(cnt_row);
    off_byte = off_col + 6'(cnt_col);
  end

  // Flatten bank group over ranks and bank over bank groups
  always_comb begin
    bg_nxt   = 8'(asm_bgf_r) + (8'(asm_rk_r) << cnt_bg);
    bank_nxt = 14'(asm_bkf_r) + (14'(bg_nxt) << cnt_bk);
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r      <= '0;
      gat_v_r    <= 1'b0;
      asm_v_r    <= 1'b0;
      out_v_r    <= 1'b0;
      for (int e = 0; e < NX; e++) xor_en_r[e] <= 1'b0;
      cfg_ch_r   <= '0;
      cfg_rk_r   <= '0;
      cfg_bg_r   <= '0;
      cfg_bk_r   <= '0;
      cfg_row_r  <= '0;
      cfg_col_r  <= '0;
      cfg_byte_r <= '0;
      cfg_aw_r   <= dam_pkg::ADDR_BITS_RST;
    end else begin
      if (adv[0]) p_v_r[0] <= in_tvalid;
      for (int s = 1; s <= XS; s++) begin
        if (adv[s]) p_v_r[s] <= p_v_r[s-1];
      end
      if (gat_adv) gat_v_r <= p_v_r[XS] && p_r[XS].op == dam_pkg::OP_DECODE;
      if (asm_adv) asm_v_r <= gat_v_r;
      if (out_adv) out_v_r <= asm_v_r;
      for (int e = 0; e < NX; e++) begin
        if (xor_wr[e]) xor_en_r[e] <= p_r[e/XPS].en;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          dam_pkg::REG_CHANNEL_BITS:   cfg_ch_r   <= cfg_data[2:0];
          dam_pkg::REG_RANK_BITS:      cfg_rk_r   <= cfg_data[2:0];
          dam_pkg::REG_BANKGROUP_BITS: cfg_bg_r   <= cfg_data[2:0];
          dam_pkg::REG_BANK_BITS:      cfg_bk_r   <= cfg_data[2:0];
          dam_pkg::REG_ROW_BITS:       cfg_row_r  <= cfg_data[4:0];
          dam_pkg::REG_COLUMN_BITS:    cfg_col_r  <= cfg_data[4:0];
          dam_pkg::REG_BYTE_BITS:      cfg_byte_r <= cfg_data[3:0];
          dam_pkg::REG_ADDR_BITS:      cfg_aw_r   <= cfg_data[6:0];
          default: ;
        endcase
      end
    end
  end

  // Payload and table contents
  always_ff @(posedge clk) begin
    if (adv[0]) p_r[0] <= in_item;
    for (int s = 1; s <= XS; s++) begin
      if (adv[s]) p_r[s] <= x_nxt[s];
    end
    for (int e = 0; e < NX; e++) begin
      if (xor_wr[e]) begin
        xor_first_r[e]  <= p_r[e/XPS].fb;
        xor_second_r[e] <= p_r[e/XPS].sb;
      end
    end
    for (int k = 0; k < NS; k++) begin
      if (slot_wr[k]) slot_r[k] <= p_r[XS].fb;
    end
    // gather
    if (gat_adv) begin
      gat_bits_r <= g_nxt;
      gat_oor_r  <= p_r[XS].oor;
    end
    // field extract
    if (asm_adv) begin
      asm_ch_r   <= 4'(20'(gat_bits_r) & dam_pkg::low_mask(5'(cnt_ch)));
      asm_rk_r   <= 4'(20'(gat_bits_r >> off_rk) & dam_pkg::low_mask(5'(cnt_rk)));
      asm_bgf_r  <= 4'(20'(gat_bits_r >> off_bg) & dam_pkg::low_mask(5'(cnt_bg)));
      asm_bkf_r  <= 6'(20'(gat_bits_r >> off_bk) & dam_pkg::low_mask(5'(cnt_bk)));
      asm_row_r  <= 20'(gat_bits_r >> off_row) & dam_pkg::low_mask(cnt_row);
      asm_col_r  <= 16'(20'(gat_bits_r >> off_col) & dam_pkg::low_mask(cnt_col));
      asm_byte_r <= 8'(20'(gat_bits_r >> off_byte) & dam_pkg::low_mask(5'(cnt_byte)));
      asm_oor_r  <= gat_oor_r;
    end
    // output register
    if (out_adv) begin
      out_ch_r   <= asm_ch_r;
      out_rk_r   <= asm_rk_r;
      out_bg_r   <= bg_nxt;
      out_bank_r <= bank_nxt;
      out_row_r  <= asm_row_r;
      out_col_r  <= asm_col_r;
      out_byte_r <= asm_byte_r;
      out_oor_r  <= asm_oor_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'd0, out_oor_r, out_byte_r, out_col_r, out_row_r,
                       out_bank_r, out_bg_r, out_rk_r, out_ch_r};

  // Input back-pressure only when every stage holds a word
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (&p_v_r) && gat_v_r && asm_v_r && out_v_r)
    else $error("input stalled with an empty stage");

  // Table writes and unused operations never set the gather stage valid
  a_drop_writes: assert property (@(posedge clk) disable iff (!rst_n)
    $past(gat_adv) && $past(p_v_r[XS]) && $past(p_r[XS].op) != dam_pkg::OP_DECODE
    |-> !gat_v_r)
    else $error("non-decode word passed the gather stage");

  // A new output word comes from a full extract stage
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(asm_v_r))
    else $error("output valid without a source word");

endmodule

`default_nettype wire
